### rtl/sequential_list_engine_top_assert.svh
// ---------------------------------------------------------------------------
// Sequential list engine assertion macros
// Shared property macros for the concurrent checks of the list engine.
// ---------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sle_pkg.sv
// ---------------------------------------------------------------------------
// Sequential list engine package
// Field widths, operation and status codes, and the sequencer state type.
// ---------------------------------------------------------------------------
package sle_pkg;

   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;

   // Request beat: tdata holds value then position, padded to whole bytes.
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = KIND_W;
   // Response beat: status, index, count, padded to whole bytes.
   localparam int RSP_DATA_W = 16;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_FIND   = 2'd0;
   localparam kind_type KIND_INSERT = 2'd1;
   localparam kind_type KIND_DELETE = 2'd2;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_FULL     = 2'd1;
   localparam status_type ST_BADPOS   = 2'd2;
   localparam status_type ST_NOTFOUND = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_SHIFT,
      S_PUT,
      S_DONE
   } state_type;

endpackage

### rtl/sequential_list_engine_top.sv
// ---------------------------------------------------------------------------
// Sequential list engine
// Dense ordered list with find, insert-at-position and delete-at-position.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Contents
//   req_*     in         req_tvalid/tready    tuser: kind; tdata: value, position
//   rsp_*     out        rsp_tvalid/tready    tdata: status, index, count
//
// The elements live in a memory with one write port and one registered read
// port, and one sequencer walks it one element per cycle. A find reads from
// index 0 until it hits a match or runs out of elements; an insert moves the
// elements from the slot to the tail one place up, last first, and then
// writes the value into the slot, and a delete moves the elements after the
// slot one place down. Rejected requests and the unused kind code go
// straight to the done state. Reset empties the list by clearing the element
// count and idles the sequencer; the store itself is not cleared because no
// entry at or beyond the count is ever read. A new request beat is taken
// whenever the sequencer is idle, even while a response beat still waits in
// the output register; the sequencer then holds its finished result until
// that register frees up.
//
module sequential_list_engine_top #(
   parameter int CAPACITY  = 64,
   parameter int ELEM_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] value, [39:32] position
   input  logic [sle_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  logic [sle_pkg::REQ_USER_W-1:0]   req_tuser,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [7:2] index, [14:8] count, [15] zero
   output logic [sle_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import sle_pkg::*;

   // Address width of the element store and width of the element count.
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);
   // Width that holds both the count and a position plus one without loss.
   localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

   // ------------------------------------------------------------------
   // Element store
   // ------------------------------------------------------------------
   logic [ELEM_BITS-1:0] mem [CAPACITY];
   logic [ELEM_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [ELEM_BITS-1:0] mem_wd;
   logic                 mem_re;
   logic [AW-1:0]        mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [LW-1:0]        rem_ff, rem_in;      // reads still to issue
   logic [AW-1:0]        ptr_ff, ptr_in;      // next read address
   logic [AW-1:0]        dst_ff, dst_in;      // write address for rdata_ff
   logic [AW-1:0]        cmp_ff, cmp_in;      // address that rdata_ff came from
   logic [AW-1:0]        slot_ff, slot_in;    // insert slot (position - 1)
   logic                 pend_ff, pend_in;    // rdata_ff holds a fresh read
   logic                 up_ff, up_in;        // shift direction: toward the end
   kind_type             op_ff, op_in;
   status_type           st_ff, st_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [ELEM_BITS-1:0] val_ff, val_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic                 hit;
   logic                 done_go;
   logic [CW-1:0]        len_x;
   logic [CW-1:0]        pos_x;
   kind_type             req_kind;
   logic [POS_W-1:0]     req_pos;
   logic [VALUE_W-1:0]   req_value;

   assign req_kind  = req_tuser[KIND_W-1:0];
   assign req_value = req_tdata[VALUE_W-1:0];
   assign req_pos   = req_tdata[VALUE_W +: POS_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign len_x      = CW'(len_ff);
   assign pos_x      = CW'(req_pos);
   assign hit        = pend_ff && (rdata_ff == val_ff);
   assign done_go    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_FIND: begin
                     state_in = S_FIND;
                  end
                  KIND_INSERT: begin
                     if (len_x >= CW'(CAPACITY) || pos_x == '0 ||
                         pos_x > len_x + CW'(1)) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SHIFT;
                     end
                  end
                  KIND_DELETE: begin
                     if (pos_x == '0 || pos_x > len_x) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SHIFT;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (hit || (!pend_ff && rem_ff == '0)) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            if (rem_ff == '0 && !pend_ff) begin
               state_in = up_ff ? S_PUT : S_DONE;
            end
         end
         S_PUT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (done_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath and store control
   // ------------------------------------------------------------------
   always_comb begin
      len_in       = len_ff;
      rem_in       = rem_ff;
      ptr_in       = ptr_ff;
      dst_in       = dst_ff;
      cmp_in       = cmp_ff;
      slot_in      = slot_ff;
      pend_in      = 1'b0;
      up_in        = up_ff;
      op_in        = op_ff;
      st_in        = st_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = dst_ff;
      mem_wd       = rdata_ff;
      mem_re       = 1'b0;
      mem_ra       = ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_kind;
               val_in  = ELEM_BITS'(req_value);
               st_in   = ST_OK;
               idx_in  = '0;
               slot_in = AW'(pos_x - CW'(1));
               case (req_kind)
                  KIND_FIND: begin
                     ptr_in = '0;
                     rem_in = len_ff;
                  end
                  KIND_INSERT: begin
                     if (len_x >= CW'(CAPACITY)) begin
                        st_in = ST_FULL;
                     end else if (pos_x == '0 || pos_x > len_x + CW'(1)) begin
                        st_in = ST_BADPOS;
                     end
                     // Move elements from the tail down to the slot, last first.
                     up_in  = 1'b1;
                     ptr_in = AW'(len_x - CW'(1));
                     rem_in = LW'(len_x - pos_x + CW'(1));
                  end
                  KIND_DELETE: begin
                     if (pos_x == '0 || pos_x > len_x) begin
                        st_in = ST_BADPOS;
                     end
                     // Move elements after the slot one place down, first first.
                     up_in  = 1'b0;
                     ptr_in = AW'(pos_x);
                     rem_in = LW'(len_x - pos_x);
                  end
                  default: begin
                     st_in = ST_OK;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (hit) begin
               idx_in = cmp_ff;
            end else if (rem_ff != '0) begin
               mem_re  = 1'b1;
               cmp_in  = ptr_ff;
               ptr_in  = ptr_ff + AW'(1);
               rem_in  = rem_ff - LW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               st_in = ST_NOTFOUND;
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (rem_ff != '0) begin
               mem_re  = 1'b1;
               ptr_in  = up_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
               dst_in  = up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
               rem_in  = rem_ff - LW'(1);
               pend_in = 1'b1;
            end
         end
         S_PUT: begin
            mem_we = 1'b1;
            mem_wa = slot_ff;
            mem_wd = val_ff;
         end
         S_DONE: begin
            if (done_go) begin
               if (st_ff == ST_OK && op_ff == KIND_INSERT) begin
                  len_in = len_ff + LW'(1);
               end else if (st_ff == ST_OK && op_ff == KIND_DELETE) begin
                  len_in = len_ff - LW'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({COUNT_W'(len_in), INDEX_W'(idx_ff), st_ff});
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      dst_ff      <= dst_in;
      cmp_ff      <= cmp_in;
      slot_ff     <= slot_in;
      up_ff       <= up_in;
      op_ff       <= op_in;
      st_ff       <= st_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`include "sequential_list_engine_top_assert.svh"

   // The element count never grows past the capacity.
   `SLE_ASSERT_SAME(a_len_bound, clock, reset, 1'b1, len_ff <= LW'(CAPACITY), "count exceeds capacity")

   // An accepted request always starts the sequencer.
   `SLE_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != S_IDLE, "accepted request left sequencer idle")

   // A successful insert grows the list by exactly one element.
   `SLE_ASSERT_NEXT(a_insert_grow, clock, reset, done_go && st_ff == ST_OK && op_ff == KIND_INSERT, len_ff == $past(len_ff) + LW'(1), "insert did not grow the list by one")

endmodule

### tb/sle_list_monitor.sv
// ---------------------------------------------------------------------------
// List engine monitor
// Watches the request and response streams of the list engine, keeps its own
// copy of the list, and compares every response beat field by field.
// ---------------------------------------------------------------------------
module sle_list_monitor #(
   parameter int CAPACITY  = 64,
   parameter int ELEM_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // [31:0] value, [39:32] position
   input  logic [sle_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  logic [sle_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [7:2] index, [14:8] count, [15] zero
   input  logic [sle_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output int                               mismatches,
   output int                               outstanding,
   output int                               list_count
);
   import sle_pkg::*;

   typedef struct packed {
      logic                 pad;
      logic [COUNT_W-1:0]   count;
      logic [INDEX_W-1:0]   index;
      status_type           status;
   } list_result_t;

   logic [ELEM_BITS-1:0] elements [CAPACITY];
   int                   held;
   list_result_t         awaited_results [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      list_count  = 0;
      held        = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
   endtask

   // Applies one request to the local list and returns the response it earns.
   function automatic list_result_t apply_list_request(input kind_type kind,
                                                       input logic [VALUE_W-1:0] value,
                                                       input logic [POS_W-1:0] pos);
      list_result_t         r;
      logic [ELEM_BITS-1:0] v;
      int                   p;
      int                   j;
      r = '0;
      v = ELEM_BITS'(value);
      p = pos;
      case (kind)
         KIND_FIND: begin
            r.status = ST_NOTFOUND;
            for (j = 0; j < held && r.status != ST_OK; j++) begin
               if (elements[j] == v) begin
                  r.status = ST_OK;
                  r.index  = j[INDEX_W-1:0];
               end
            end
         end
         KIND_INSERT: begin
            if (held >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (p < 1 || p > held + 1) begin
               r.status = ST_BADPOS;
            end else begin
               for (j = held; j >= p; j--) elements[j] = elements[j-1];
               elements[p-1] = v;
               held++;
            end
         end
         KIND_DELETE: begin
            if (p < 1 || p > held) begin
               r.status = ST_BADPOS;
            end else begin
               for (j = p; j < held; j++) elements[j-1] = elements[j];
               held--;
            end
         end
         default: ;
      endcase
      r.count = held[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      list_result_t got;
      list_result_t want;
      if (reset) begin
         held = 0;
         awaited_results.delete();
      end else begin
         // A response always belongs to an earlier request, so it is matched
         // before a request taken at the same edge is queued.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("response beat 0x%h with no request outstanding",
                                         rsp_tdata));
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status got %0d, expected %0d",
                                            got.status, want.status));
               if (got.index !== want.index)
                  report_mismatch($sformatf("index got %0d, expected %0d",
                                            got.index, want.index));
               if (got.count !== want.count)
                  report_mismatch($sformatf("count got %0d, expected %0d",
                                            got.count, want.count));
               if (got.pad !== want.pad)
                  report_mismatch($sformatf("padding bit got %b, expected 0", got.pad));
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(apply_list_request(req_tuser,
                                                         req_tdata[VALUE_W-1:0],
                                                         req_tdata[VALUE_W +: POS_W]));
      end
      outstanding <= awaited_results.size();
      list_count  <= held;
   end

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// List engine testbench
// Drives find, insert, delete and unused-kind requests into the list engine
// under random back-pressure and idle gaps; a separate monitor predicts and
// checks every response beat, and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb;
   import sle_pkg::*;

   localparam int CAPACITY  = 64;
   localparam int ELEM_BITS = 32;

   // The fourth kind code has no meaning; the engine must answer it harmlessly.
   localparam kind_type KIND_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 1250;
   localparam int PHASE_B_START = 450;
   localparam int PHASE_C_START = 850;
   // The longest operation walks the whole list once, well under this margin.
   localparam int DRAIN_CYCLES  = 300;
   // Watchdog time limit, many times the slowest correct run.
   localparam longint RUN_LIMIT = 64'd20_000_000;

   // Operation mix of a stretch of random traffic. Growing stretches are what
   // drive the list up to capacity, shrinking ones bring it back to empty.
   typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // [31:0] value, [39:32] position
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   // [1:0] kind
   logic [REQ_USER_W-1:0]   req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [1:0] status, [7:2] index, [14:8] count, [15] zero
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   int mismatches;
   int outstanding;
   int list_count;

   // Percent chance, per cycle, that the sender holds off or the receiver stalls.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // A few recent values, reused so that finds hit and duplicates get stored.
   logic [VALUE_W-1:0] value_pool [8];

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   sequential_list_engine_top #(
      .CAPACITY  (CAPACITY),
      .ELEM_BITS (ELEM_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sle_list_monitor #(
      .CAPACITY  (CAPACITY),
      .ELEM_BITS (ELEM_BITS)
   ) u_list_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .list_count  (list_count)
   );

   // The receiver decides afresh every cycle whether to take a response beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Presents one request beat and returns in the time step of its acceptance
   // with req_tvalid still high, so that a following beat can go out back to
   // back without valid being lowered and raised in the same step.
   task automatic send_req(input kind_type kind, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {pos, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops sending and waits until every predicted response has been taken.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Builds one random request from the current mix. The list length seen here
   // may lag by the one request still in flight, which only moves a position
   // by one and so lands on a boundary case now and then.
   task automatic send_random_item(input mix_type mix);
      int                 roll;
      int                 len;
      int                 p;
      int                 find_lim;
      int                 insert_lim;
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      len = list_count;
      case (mix)
         MIX_GROW: begin
            find_lim   = 20;
            insert_lim = 85;
         end
         MIX_SHRINK: begin
            find_lim   = 20;
            insert_lim = 35;
         end
         default: begin
            find_lim   = 30;
            insert_lim = 63;
         end
      endcase
      roll = $urandom_range(99);
      if (roll < find_lim)        kind = KIND_FIND;
      else if (roll < insert_lim) kind = KIND_INSERT;
      else if (roll < 97)         kind = KIND_DELETE;
      else                        kind = KIND_UNUSED;

      // Values: half from the pool, a few at the extremes, the rest fresh.
      roll = $urandom_range(99);
      if (roll < 50) begin
         value = value_pool[$urandom_range(7)];
      end else if (roll < 55) begin
         value = '0;
      end else if (roll < 60) begin
         value = '1;
      end else begin
         value = $urandom;
         if (kind == KIND_INSERT) value_pool[$urandom_range(7)] = value;
      end

      // Positions: mostly legal with the ends favored, otherwise any byte.
      if ($urandom_range(99) < 88) begin
         case ($urandom_range(2))
            0:       p = 1;
            1:       p = (kind == KIND_INSERT) ? len + 1 : len;
            default: p = $urandom_range(len + 1, 1);
         endcase
      end else begin
         p = $urandom_range(255);
      end
      send_req(kind, value, p[POS_W-1:0]);
   endtask

   initial begin : stimulus
      int      seg_left;
      mix_type mix;
      foreach (value_pool[i]) value_pool[i] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Phase A: the sender idles a little, the receiver stalls a lot.
      send_idle_pct = 20;
      rsp_stall_pct = 71;
      @(posedge clock);

      // Directed part. An empty list rejects finds and deletes, and the
      // position checks are hit at zero, just past the end and at the top.
      send_req(KIND_FIND,   32'h0000_0000, 8'd0);
      send_req(KIND_DELETE, 32'h0000_0000, 8'd1);
      send_req(KIND_DELETE, 32'hFFFF_FFFF, 8'd0);
      send_req(KIND_INSERT, 32'h0000_0001, 8'd0);
      send_req(KIND_INSERT, 32'h0000_0001, 8'd2);
      // Build a short list by inserting at the front, the end and the middle,
      // with the value extremes and a duplicate that must be found first.
      send_req(KIND_INSERT, 32'h0000_0000, 8'd1);
      send_req(KIND_INSERT, 32'hFFFF_FFFF, 8'd2);
      send_req(KIND_INSERT, 32'h1234_5678, 8'd1);
      send_req(KIND_INSERT, 32'hA5A5_A5A5, 8'd2);
      send_req(KIND_INSERT, 32'h5A5A_5A5A, 8'd255);
      send_req(KIND_INSERT, 32'hFFFF_FFFF, 8'd1);
      send_req(KIND_FIND,   32'hFFFF_FFFF, 8'd0);
      send_req(KIND_FIND,   32'h0000_0000, 8'd0);
      send_req(KIND_FIND,   32'h1234_5678, 8'd0);
      send_req(KIND_FIND,   32'hDEAD_BEEF, 8'd3);
      send_req(KIND_UNUSED, 32'h3C3C_C3C3, 8'd1);
      // The list now holds five elements.
      send_req(KIND_DELETE, 32'h0000_0000, 8'd6);
      send_req(KIND_DELETE, 32'h0000_0000, 8'd255);
      send_req(KIND_DELETE, 32'hFFFF_FFFF, 8'd5);
      send_req(KIND_DELETE, 32'h0000_0000, 8'd1);
      send_req(KIND_DELETE, 32'h1234_5678, 8'd2);
      send_req(KIND_FIND,   32'hA5A5_A5A5, 8'd255);
      send_req(KIND_UNUSED, 32'hFFFF_FFFF, 8'd255);

      // Let everything settle once before the random traffic starts.
      wait_for_drain();

      // The first random stretch grows the list up to capacity so that
      // the full-list rejection is reached early.
      mix      = MIX_GROW;
      seg_left = 160;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PHASE_B_START) begin
            // Phase B: the roles swap, the sender idles a lot.
            wait_for_drain();
            send_idle_pct = 71;
            rsp_stall_pct = 20;
         end else if (i == PHASE_C_START) begin
            // Phase C: both sides run flat out.
            wait_for_drain();
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         if (seg_left == 0) begin
            case ($urandom_range(2))
               0:       mix = MIX_GROW;
               1:       mix = MIX_SHRINK;
               default: mix = MIX_CHURN;
            endcase
            seg_left = $urandom_range(150, 30);
         end
         send_random_item(mix);
         seg_left--;
      end

      // Wait out the last responses, then give the engine time to show any
      // stray beat before the verdict.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Guards against a hung handshake.
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/sle_pkg.sv
rtl/sequential_list_engine_top.sv
tb/sle_list_monitor.sv
tb/tb.sv
